/* sv/ibba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bounding box accumulator package
// Shared widths, codes and decode constants for the box accumulator.
// ----------------------------------------------------------------------------
package ibba_pkg;

    // default sizing of the top level
    localparam int CLASS_ENTRIES_DEF = 16;
    localparam int BOX_COUNT_DEF     = 256;
    localparam int COORD_BITS_DEF    = 12;

    // beat layouts
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int CFG_W     = 5;
    localparam int FIELD_W   = 12;

    // function codes carried in s_tuser
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_PIXEL  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // status codes carried in m_tuser
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_NO_CLASS = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // pixel value decode: class = v div 1000 via reciprocal multiply
    localparam logic [15:0] VALUE_MIN     = 16'd256;
    localparam logic [15:0] VALUE_INVALID = 16'd65535;
    localparam logic [9:0]  INST_RADIX    = 10'd1000;
    localparam logic [16:0] DIV_MUL       = 17'd67109;   // ceil(2^26 / 1000)
    localparam int          DIV_SHIFT     = 26;

endpackage : ibba_pkg
`default_nettype wire

/* sv/instance_bounding_box_accumulator_top.sv */
// From an accepted beat to m_tvalid: a load, an unused function or an out of range pixel
// or box index goes straight to the result state; a box read reads the box store; a pixel
// scans the saturated class_count of entries and widens its box if the class is found and
// the box index fits. Throughput: one item at a time; s_tready returns as the result loads;
// the scan reads one class entry a cycle, then one box RMW. Reset: aresetn low clears control
// state and class_count; a clearing pass then empties every box before s_tready rises.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bounding box accumulator
// Decodes instance-map pixels, finds the class base offset in a class table
// memory and widens the addressed box held in a box memory.
// ----------------------------------------------------------------------------
module instance_bounding_box_accumulator_top #(
    parameter int CLASS_ENTRIES = ibba_pkg::CLASS_ENTRIES_DEF,
    parameter int BOX_COUNT     = ibba_pkg::BOX_COUNT_DEF,
    parameter int COORD_BITS    = ibba_pkg::COORD_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration write: class_count
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [ibba_pkg::CFG_W-1:0]      cfg_data,
    // input beats
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // pixel_value[15:0] col[27:16] row[39:28] entry_index[43:40]
    // class_code[50:44] base_offset[58:51] box_index[66:59] zero[71:67]
    input  wire  [ibba_pkg::S_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  wire  [ibba_pkg::S_TUSER_W-1:0]  s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // min_col[11:0] max_col[23:12] min_row[35:24] max_row[47:36]
    output logic [ibba_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [ibba_pkg::M_TUSER_W-1:0]  m_tuser
);
    import ibba_pkg::*;

    localparam int IW   = (CLASS_ENTRIES > 1) ? $clog2(CLASS_ENTRIES) : 1;
    localparam int NW   = $clog2(CLASS_ENTRIES + 1);
    localparam int BW   = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
    localparam int CB   = COORD_BITS;
    localparam int BOXW = 4 * CB;
    localparam int TBLW = 15;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DECODE = 8'b0000_0100,
        ST_SEARCH = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_BOXRD  = 8'b0010_0000,
        ST_RESULT = 8'b0100_0000
    } state_t;

    // empty box: mins all ones, maxes zero; word is {max_row,min_row,max_col,min_col}
    localparam logic [BOXW-1:0] BOX_EMPTY = {{CB{1'b0}}, {CB{1'b1}}, {CB{1'b0}}, {CB{1'b1}}};

    // ---------------- input field split ----------------
    logic [15:0] in_value;
    logic [11:0] in_col, in_row;
    logic [3:0]  in_entry;
    logic [6:0]  in_code;
    logic [7:0]  in_base;
    logic [7:0]  in_box;
    logic [1:0]  in_func;

    assign in_value = s_tdata[15:0];
    assign in_col   = s_tdata[27:16];
    assign in_row   = s_tdata[39:28];
    assign in_entry = s_tdata[43:40];
    assign in_code  = s_tdata[50:44];
    assign in_base  = s_tdata[58:51];
    assign in_box   = s_tdata[66:59];
    assign in_func  = s_tuser[1:0];

    // coordinate and index width adaption
    logic [CB+11:0] col_ext, row_ext;
    logic [IW+3:0]  entry_ext;
    logic [BW+7:0]  rbox_ext;
    assign col_ext   = {{CB{1'b0}}, in_col};
    assign row_ext   = {{CB{1'b0}}, in_row};
    assign entry_ext = {{IW{1'b0}}, in_entry};
    assign rbox_ext  = {{BW{1'b0}}, in_box};

    // ---------------- registers ----------------
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] class_count_reg;
    logic [BW-1:0]    clr_idx_reg, clr_idx_next;
    logic             is_read_reg, is_read_next;
    logic [15:0]      value_reg, value_next;
    logic [6:0]       cls_reg, cls_next;
    logic [9:0]       inst_reg, inst_next;
    logic [CB-1:0]    x_reg, x_next, y_reg, y_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    rd_idx_reg, rd_idx_next;
    logic [IW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic             hit_zero_reg, hit_zero_next;
    logic [7:0]       base_reg, base_next;
    logic [7:0]       prev_off_reg, prev_off_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [M_TDATA_W-1:0] res_data_reg, res_data_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // ---------------- memories ----------------
    logic [TBLW-1:0] tbl_mem [CLASS_ENTRIES];
    logic [TBLW-1:0] tbl_rdata_reg;
    logic            tbl_wr_en, tbl_rd_en;
    logic [IW-1:0]   tbl_wr_addr, tbl_rd_addr;
    logic [TBLW-1:0] tbl_wr_data;

    logic [BOXW-1:0] box_mem [BOX_COUNT];
    logic [BOXW-1:0] box_rdata_reg;
    logic            box_wr_en, box_rd_en;
    logic [BW-1:0]   box_wr_addr, box_rd_addr, box_addr_reg, box_addr_next;
    logic [BOXW-1:0] box_wr_data;

    // class table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (tbl_wr_en) begin
            tbl_mem[tbl_wr_addr] <= tbl_wr_data;
        end
        if (tbl_rd_en) begin
            tbl_rdata_reg <= tbl_mem[tbl_rd_addr];
        end
    end

    // box store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (box_wr_en) begin
            box_mem[box_wr_addr] <= box_wr_data;
        end
        if (box_rd_en) begin
            box_rdata_reg <= box_mem[box_rd_addr];
        end
    end

    // ---------------- datapath helpers ----------------
    logic [32:0]    div_prod;
    logic [16:0]    cls_scaled;
    logic [NW-1:0]  n_sat;
    logic [6:0]     tbl_code;
    logic [7:0]     tbl_off;
    logic [10:0]    box_sum;
    logic [BW+10:0] box_sum_ext;
    logic [CB-1:0]  b_min_col, b_max_col, b_min_row, b_max_row;
    logic [CB-1:0]  u_min_col, u_max_col, u_min_row, u_max_row;
    logic [CB+11:0] o_min_col, o_max_col, o_min_row, o_max_row;

    assign div_prod    = 33'(in_value) * 33'(DIV_MUL);
    assign cls_scaled  = 17'(cls_reg) * 17'(INST_RADIX);
    assign n_sat       = (32'(class_count_reg) > CLASS_ENTRIES) ? NW'(CLASS_ENTRIES)
                                                                 : NW'(class_count_reg);
    assign tbl_code    = tbl_rdata_reg[14:8];
    assign tbl_off     = tbl_rdata_reg[7:0];
    assign box_sum     = 11'(base_reg) + 11'(inst_reg);
    assign box_sum_ext = {{BW{1'b0}}, box_sum};

    assign b_min_col = box_rdata_reg[CB-1:0];
    assign b_max_col = box_rdata_reg[2*CB-1:CB];
    assign b_min_row = box_rdata_reg[3*CB-1:2*CB];
    assign b_max_row = box_rdata_reg[4*CB-1:3*CB];

    // independent min and max widening
    assign u_min_col = (x_reg < b_min_col) ? x_reg : b_min_col;
    assign u_max_col = (x_reg > b_max_col) ? x_reg : b_max_col;
    assign u_min_row = (y_reg < b_min_row) ? y_reg : b_min_row;
    assign u_max_row = (y_reg > b_max_row) ? y_reg : b_max_row;

    assign o_min_col = {12'd0, b_min_col};
    assign o_max_col = {12'd0, b_max_col};
    assign o_min_row = {12'd0, b_min_row};
    assign o_max_row = {12'd0, b_max_row};

    // ---------------- control ----------------
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        is_read_next    = is_read_reg;
        value_next      = value_reg;
        cls_next        = cls_reg;
        inst_next       = inst_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        hit_zero_next   = hit_zero_reg;
        base_next       = base_reg;
        prev_off_next   = prev_off_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        box_addr_next   = box_addr_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        tbl_wr_en   = 1'b0;
        tbl_wr_addr = entry_ext[IW-1:0];
        tbl_wr_data = {in_code, in_base};
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = rd_idx_reg[IW-1:0];
        box_wr_en   = 1'b0;
        box_wr_addr = box_addr_reg;
        box_wr_data = BOX_EMPTY;
        box_rd_en   = 1'b0;
        box_rd_addr = rbox_ext[BW-1:0];

        // output register drains independently of the item in flight
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            // clearing pass over the box store after reset
            ST_CLEAR: begin
                box_wr_en   = 1'b1;
                box_wr_addr = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == BW'(BOX_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            // take one beat and dispatch on func
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_status_next = STAT_OK;
                    res_data_next   = '0;
                    value_next      = in_value;
                    cls_next        = div_prod[DIV_SHIFT+6:DIV_SHIFT];
                    x_next          = col_ext[CB-1:0];
                    y_next          = row_ext[CB-1:0];
                    is_read_next    = 1'b0;
                    state_next      = ST_RESULT;
                    unique case (in_func)
                        FUNC_LOAD: begin
                            tbl_wr_en = (32'(in_entry) < CLASS_ENTRIES);
                        end
                        FUNC_PIXEL: begin
                            if (in_value < VALUE_MIN || in_value == VALUE_INVALID) begin
                                res_status_next = STAT_RANGE;
                            end else begin
                                state_next = ST_DECODE;
                            end
                        end
                        FUNC_READ: begin
                            if (32'(in_box) < BOX_COUNT) begin
                                box_rd_en     = 1'b1;
                                box_addr_next = rbox_ext[BW-1:0];
                                is_read_next  = 1'b1;
                                state_next    = ST_BOXRD;
                            end else begin
                                res_status_next = STAT_OVERFLOW;
                            end
                        end
                        FUNC_UNUSED: begin
                            res_status_next = STAT_OK;
                        end
                        default: begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end

            // instance = v - class*1000, start the table scan at entry 0
            ST_DECODE: begin
                inst_next     = 10'(value_reg - cls_scaled[15:0]);
                n_next        = n_sat;
                found_next    = 1'b0;
                hit_zero_next = 1'b0;
                if (n_sat == '0) begin
                    res_status_next = STAT_NO_CLASS;
                    state_next      = ST_RESULT;
                end else begin
                    tbl_rd_en    = 1'b1;
                    tbl_rd_addr  = '0;
                    rd_idx_next  = NW'(1);
                    cmp_idx_next = '0;
                    state_next   = ST_SEARCH;
                end
            end

            // compare the entry read last cycle, issue the next read
            ST_SEARCH: begin
                if (tbl_code == cls_reg) begin
                    found_next    = 1'b1;
                    hit_zero_next = (cmp_idx_reg == '0);
                    base_next     = prev_off_reg;
                end
                prev_off_next = tbl_off;
                if (rd_idx_reg == n_reg) begin
                    state_next = ST_CHECK;
                end else begin
                    tbl_rd_en    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
            end

            // resolve the match and bound the box index
            ST_CHECK: begin
                if (!found_reg || hit_zero_reg) begin
                    res_status_next = STAT_NO_CLASS;
                    state_next      = ST_RESULT;
                end else if (32'(box_sum) >= BOX_COUNT) begin
                    res_status_next = STAT_OVERFLOW;
                    state_next      = ST_RESULT;
                end else begin
                    box_rd_en     = 1'b1;
                    box_rd_addr   = box_sum_ext[BW-1:0];
                    box_addr_next = box_sum_ext[BW-1:0];
                    state_next    = ST_BOXRD;
                end
            end

            // box data is back: widen and write back, or read out and clear the box
            ST_BOXRD: begin
                box_wr_en = 1'b1;
                if (is_read_reg) begin
                    box_wr_data   = BOX_EMPTY;
                    res_data_next = {o_max_row[11:0], o_min_row[11:0],
                                     o_max_col[11:0], o_min_col[11:0]};
                end else begin
                    box_wr_data = {u_max_row, u_min_row, u_max_col, u_min_col};
                end
                state_next = ST_RESULT;
            end

            // hand the result to the output register
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            class_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                class_count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        is_read_reg    <= is_read_next;
        value_reg      <= value_next;
        cls_reg        <= cls_next;
        inst_reg       <= inst_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        n_reg          <= n_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        hit_zero_reg   <= hit_zero_next;
        base_reg       <= base_next;
        prev_off_reg   <= prev_off_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        box_addr_reg   <= box_addr_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule : instance_bounding_box_accumulator_top
`default_nettype wire

/* sv/ibba_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bounding box accumulator port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ibba_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [ibba_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [ibba_pkg::M_TUSER_W-1:0]   m_tuser
);
    import ibba_pkg::*;

    // one item in flight: an accepted beat closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is still in flight");

    // a result appears together with the input side reopening
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while the item is still in flight");

    // out of reset the result side is empty and the input side stays closed
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("ports not idle after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule : ibba_checker

bind instance_bounding_box_accumulator_top ibba_checker u_ibba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
